### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, entry layout and ordering rule of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 16;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int CIDX_W       = ADDR_W + 2;   // holds 2*slot+2

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [31:0]       prio;
    logic [31:0]              seq;
    logic [PAYLOAD_BITS-1:0]  payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // a is served before b: lower priority, then lower sequence number
  function automatic logic served_first(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio < b.prio;
    return a.seq < b.seq;
  endfunction

endpackage

### design/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Stable min-priority queue kept as a binary heap in one RAM.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_*    | slave     | tuser: op; tdata: priority_req, payload
//  out_*   | master    | tuser: status; tdata: head fields, entry_count
//
//  Push: the new entry climbs, one parent compared per step (up to 6 for 64 entries).
//  Pop: the last entry moves to the root and sifts down one level per S_RL,
//  S_RR, S_CMP pass; popping the last entry needs no sift. Each level reads two
//  children through the single RAM read port. Peek, clear and errors go to S_DONE.
//  Synchronous active-low reset empties the queue; RAM contents persist.
//  A new op is taken while a result waits; the next result waits for out_tready.
// ----------------------------------------------------------------------------
module stable_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic [47:0] in_tdata,   // [31:0] priority_req, [47:32] payload
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [55:0] out_tdata   // [0] head_valid, [32:1] head_priority,
                                  // [48:33] head_payload, [55:49] entry_count
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_RL   = 3'd3;
  localparam logic [2:0] S_RR   = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;
  entry_t            item_r, item_nxt;     // entry being sifted
  entry_t            left_r, left_nxt;
  entry_t            head_r;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [55:0]       out_data_r;
  logic              fill_pend_r;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic [CIDX_W-1:0] left_i, right_i, cnt_i;
  logic [ADDR_W-1:0] parent;
  entry_t            new_e;
  logic              take_l, take_r;

  spq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata   = entry_t'(rdata_raw);
  assign left_i  = {1'b0, slot_r, 1'b1};
  assign right_i = left_i + CIDX_W'(1);
  assign cnt_i   = CIDX_W'(count_r);
  assign parent  = (slot_r - ADDR_W'(1)) >> 1;
  assign new_e   = '{prio: in_tdata[31:0], seq: seq_r, payload: in_tdata[47:32]};
  assign take_l  = served_first(left_r, item_r);
  assign take_r  = (right_i < cnt_i) && served_first(rdata, take_l ? left_r : item_r);

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    seq_nxt    = seq_r;
    slot_nxt   = slot_r;
    item_nxt   = item_r;
    left_nxt   = left_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = slot_r;
    wdata      = item_r;
    raddr      = parent;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_tuser)
            OP_PUSH: begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                item_nxt  = new_e;
                seq_nxt   = seq_r + 32'd1;
                count_nxt = count_r + CNT_W'(1);
                slot_nxt  = count_r[ADDR_W-1:0];
                raddr     = (count_r[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
                if (count_r == '0) begin
                  we    = 1'b1;
                  waddr = '0;
                  wdata = new_e;
                end else begin
                  state_nxt = S_UP;
                end
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                raddr     = ADDR_W'(count_r - CNT_W'(1));
                if (count_r != CNT_W'(1)) state_nxt = S_LAST;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              seq_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      S_UP: begin
        // rdata holds the parent entry
        we = 1'b1;
        if (served_first(item_r, rdata)) begin
          wdata    = rdata;
          slot_nxt = parent;
          raddr    = (parent - ADDR_W'(1)) >> 1;
          if (parent == '0) state_nxt = S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
        // parent wins: the new entry settles in the hole
        if (!served_first(item_r, rdata)) begin
          wdata = item_r;
        end
      end
      S_LAST: begin
        item_nxt  = rdata;
        slot_nxt  = '0;
        state_nxt = S_RL;
      end
      S_RL: begin
        raddr = left_i[ADDR_W-1:0];
        if (left_i < cnt_i) begin
          state_nxt = S_RR;
        end else begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RR: begin
        left_nxt  = rdata;
        raddr     = right_i[ADDR_W-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        we        = 1'b1;
        state_nxt = S_RL;
        if (take_r) begin
          wdata    = rdata;
          slot_nxt = right_i[ADDR_W-1:0];
        end else if (take_l) begin
          wdata    = left_r;
          slot_nxt = left_i[ADDR_W-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (fill_pend_r) begin
          we    = 1'b1;
          waddr = '0;
          wdata = item_r;
        end
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // climb finished at the root in S_UP: the held entry goes to slot 0
  logic root_fill;
  assign root_fill = (state_r == S_UP) && served_first(item_r, rdata) && (parent == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      seq_r   <= seq_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    item_r   <= item_nxt;
    left_r   <= left_nxt;
    status_r <= status_nxt;
    if (we && waddr == '0) head_r <= wdata;
    if (root_fill) head_r <= item_r;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= status_r;
      out_data_r   <= {7'(count_r),
                       (count_r != '0) ? 16'(head_r.payload) : 16'd0,
                       (count_r != '0) ? head_r.prio : 32'sd0,
                       (count_r != '0)};
    end
  end

  // second RAM write for a root fill after the last climb step
  always_ff @(posedge clk) begin
    if (!rst_n) fill_pend_r <= 1'b0;
    else        fill_pend_r <= root_fill;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

endmodule
